// File: src/hprpa_pkg.sv
package hprpa_pkg;

    localparam int ADC_W = 12;
    localparam int ZONE_W = 3;
    localparam int POS_W = 3;
    localparam int STAT_W = 2;
    localparam int DECI_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_LIMITS = 8;

    localparam int SCALE_W = 12;
    localparam int PROD_W = ADC_W + SCALE_W;
    localparam int FRAC_W = 16;

    localparam logic [SCALE_W-1:0] BATT_SCALE = 12'd2270;
    localparam logic [PROD_W-1:0] BATT_ROUND = 24'd32768;
    localparam logic [DECI_W-1:0] BATT_OK_DECIVOLTS = 8'd90;

    localparam logic [ADC_W-1:0] LIMIT_LOW_RESET = 12'd0;
    localparam logic [ADC_W-1:0] LIMIT_HIGH_RESET = 12'd4095;

    localparam logic [CFG_IDX_W-1:0] IDX_FIRST_UNDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_FIRST_INACTIVE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_FIRST_BETWEEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_FIRST_ACTIVE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_SECOND_UNDER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] IDX_SECOND_INACTIVE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] IDX_SECOND_BETWEEN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SECOND_ACTIVE = 3'd7;

    typedef logic [ZONE_W-1:0] t_zone;
    typedef logic [POS_W-1:0] t_pos;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_zone ZONE_UNDER = 3'd0;
    localparam t_zone ZONE_INACTIVE = 3'd1;
    localparam t_zone ZONE_BETWEEN = 3'd2;
    localparam t_zone ZONE_ACTIVE = 3'd3;
    localparam t_zone ZONE_OVER = 3'd4;

    localparam t_pos POS_UNKNOWN = 3'd0;
    localparam t_pos POS_LOCKED = 3'd1;
    localparam t_pos POS_BETWEEN = 3'd2;
    localparam t_pos POS_UNLOCKED = 3'd3;
    localparam t_pos POS_LOCKED_FQ = 3'd4;
    localparam t_pos POS_BETWEEN_FQ = 3'd5;
    localparam t_pos POS_UNLOCKED_FQ = 3'd6;

    localparam t_status STAT_UNKNOWN = 2'd0;
    localparam t_status STAT_UNLOCKED = 2'd1;
    localparam t_status STAT_BETWEEN = 2'd2;
    localparam t_status STAT_LOCKED = 2'd3;

    function automatic t_zone zone_of(
        input logic [ADC_W-1:0] reading,
        input logic [ADC_W-1:0] lim_under,
        input logic [ADC_W-1:0] lim_inactive,
        input logic [ADC_W-1:0] lim_between,
        input logic [ADC_W-1:0] lim_active
    );
        t_zone zone;
        if (reading < lim_under) begin
            zone = ZONE_UNDER;
        end else if (reading < lim_inactive) begin
            zone = ZONE_INACTIVE;
        end else if (reading < lim_between) begin
            zone = ZONE_BETWEEN;
        end else if (reading < lim_active) begin
            zone = ZONE_ACTIVE;
        end else begin
            zone = ZONE_OVER;
        end
        return zone;
    endfunction

    function automatic t_pos position_of(input t_zone z1, input t_zone z2);
        t_pos pos;
        pos = POS_UNKNOWN;
        case (z1)
            ZONE_UNDER, ZONE_OVER: begin
                case (z2)
                    ZONE_INACTIVE: pos = POS_UNLOCKED;
                    ZONE_BETWEEN:  pos = POS_BETWEEN;
                    ZONE_ACTIVE:   pos = POS_LOCKED;
                    default:       pos = POS_UNKNOWN;
                endcase
            end
            ZONE_INACTIVE: begin
                case (z2)
                    ZONE_UNDER:    pos = POS_LOCKED;
                    ZONE_INACTIVE: pos = POS_UNKNOWN;
                    ZONE_BETWEEN:  pos = POS_BETWEEN;
                    ZONE_ACTIVE:   pos = POS_LOCKED_FQ;
                    ZONE_OVER:     pos = POS_LOCKED;
                    default:       pos = POS_UNKNOWN;
                endcase
            end
            ZONE_BETWEEN: begin
                case (z2)
                    ZONE_BETWEEN: pos = POS_BETWEEN_FQ;
                    default:      pos = POS_BETWEEN;
                endcase
            end
            ZONE_ACTIVE: begin
                case (z2)
                    ZONE_UNDER:    pos = POS_UNLOCKED;
                    ZONE_INACTIVE: pos = POS_UNLOCKED_FQ;
                    ZONE_BETWEEN:  pos = POS_BETWEEN;
                    ZONE_ACTIVE:   pos = POS_UNKNOWN;
                    ZONE_OVER:     pos = POS_UNLOCKED;
                    default:       pos = POS_UNKNOWN;
                endcase
            end
            default: pos = POS_UNKNOWN;
        endcase
        return pos;
    endfunction

    function automatic t_status status_of(input t_pos pos);
        t_status st;
        case (pos)
            POS_LOCKED, POS_LOCKED_FQ:     st = STAT_LOCKED;
            POS_BETWEEN, POS_BETWEEN_FQ:   st = STAT_BETWEEN;
            POS_UNLOCKED, POS_UNLOCKED_FQ: st = STAT_UNLOCKED;
            default:                       st = STAT_UNKNOWN;
        endcase
        return st;
    endfunction

endpackage

// File: src/hall_pair_ring_position_arbiter.sv
// A request is taken whenever start is high; busy stays low, so one request can follow
// another in every cycle. Each request gives one result, shown for exactly one cycle with
// o_valid high; it passes through the input register, then through the zone compare, table
// lookup and battery scaling into the result register.
// The receiver cannot stall, so it must take every result in the cycle it appears.
// Threshold registers are written through the configuration channel, which is always
// ready, and should be written only while no request is in flight.
module hall_pair_ring_position_arbiter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hprpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hprpa_pkg::ADC_W-1:0]      i_cfg_data,
    input  logic                             start,
    output logic                             busy,
    input  logic [hprpa_pkg::ADC_W-1:0]      i_hall_first_reading,
    input  logic [hprpa_pkg::ADC_W-1:0]      i_hall_second_reading,
    input  logic [hprpa_pkg::ADC_W-1:0]      i_battery_sample,
    input  logic                             i_bus_ok,
    output logic                             o_valid,
    output logic [hprpa_pkg::ZONE_W-1:0]     o_first_zone,
    output logic [hprpa_pkg::ZONE_W-1:0]     o_second_zone,
    output logic [hprpa_pkg::POS_W-1:0]      o_ring_slot,
    output logic [hprpa_pkg::STAT_W-1:0]     o_ring_status,
    output logic [hprpa_pkg::DECI_W-1:0]     o_battery_decivolts,
    output logic                             o_battery_good,
    output logic                             o_system_ready
);
    import hprpa_pkg::*;

    logic [ADC_W-1:0] r_limit [NUM_LIMITS];

    logic             r_in_valid;
    logic [ADC_W-1:0] r_h1;
    logic [ADC_W-1:0] r_h2;
    logic [ADC_W-1:0] r_bs;
    logic             r_bus;

    logic              r_valid;
    t_zone             r_z1;
    t_zone             r_z2;
    t_pos              r_pos;
    t_status           r_status;
    logic [DECI_W-1:0] r_deci;
    logic              r_good;
    logic              r_ready;

    t_zone             n_z1;
    t_zone             n_z2;
    t_pos              n_pos;
    t_status           n_status;
    logic [PROD_W-1:0] n_prod;
    logic [DECI_W-1:0] n_deci;
    logic              n_good;
    logic              n_ready;

    assign busy = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit[IDX_FIRST_UNDER]     <= LIMIT_LOW_RESET;
            r_limit[IDX_FIRST_INACTIVE]  <= LIMIT_LOW_RESET;
            r_limit[IDX_FIRST_BETWEEN]   <= LIMIT_LOW_RESET;
            r_limit[IDX_FIRST_ACTIVE]    <= LIMIT_HIGH_RESET;
            r_limit[IDX_SECOND_UNDER]    <= LIMIT_LOW_RESET;
            r_limit[IDX_SECOND_INACTIVE] <= LIMIT_LOW_RESET;
            r_limit[IDX_SECOND_BETWEEN]  <= LIMIT_LOW_RESET;
            r_limit[IDX_SECOND_ACTIVE]   <= LIMIT_HIGH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
            r_valid    <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_h1  <= i_hall_first_reading;
            r_h2  <= i_hall_second_reading;
            r_bs  <= i_battery_sample;
            r_bus <= i_bus_ok;
        end
    end

    always_comb begin
        n_z1 = zone_of(r_h1, r_limit[IDX_FIRST_UNDER], r_limit[IDX_FIRST_INACTIVE],
                       r_limit[IDX_FIRST_BETWEEN], r_limit[IDX_FIRST_ACTIVE]);
        n_z2 = zone_of(r_h2, r_limit[IDX_SECOND_UNDER], r_limit[IDX_SECOND_INACTIVE],
                       r_limit[IDX_SECOND_BETWEEN], r_limit[IDX_SECOND_ACTIVE]);
        n_pos = position_of(n_z1, n_z2);
        n_status = status_of(n_pos);
        n_prod = PROD_W'({{(PROD_W-ADC_W){1'b0}}, r_bs} * {{(PROD_W-SCALE_W){1'b0}}, BATT_SCALE})
                 + BATT_ROUND;
        n_deci = n_prod[FRAC_W +: DECI_W];
        n_good = (n_deci >= BATT_OK_DECIVOLTS);
        n_ready = n_good && r_bus && (n_status == STAT_LOCKED);
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_z1     <= n_z1;
            r_z2     <= n_z2;
            r_pos    <= n_pos;
            r_status <= n_status;
            r_deci   <= n_deci;
            r_good   <= n_good;
            r_ready  <= n_ready;
        end
    end

    assign o_valid             = r_valid;
    assign o_first_zone        = r_z1;
    assign o_second_zone       = r_z2;
    assign o_ring_slot         = r_pos;
    assign o_ring_status       = r_status;
    assign o_battery_decivolts = r_deci;
    assign o_battery_good      = r_good;
    assign o_system_ready      = r_ready;

endmodule
